/* src/fsrd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrd_pkg
// Types and constants shared by the FTP stream receive decoder and its checker.
// ----------------------------------------------------------------------------
package fsrd_pkg;

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_DATA   = 3'd1,
		OP_CLOSE  = 3'd2,
		OP_FAIL   = 3'd3,
		OP_ABORT  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		STAT_BYTE   = 3'd0,
		STAT_DONE   = 3'd1,
		STAT_ABORT  = 3'd2,
		STAT_FAIL   = 3'd3,
		STAT_UNSUP  = 3'd4
	} status_t;

	localparam logic [1:0] CFG_DATA_TYPE = 2'd0;
	localparam logic [1:0] CFG_MODE      = 2'd1;
	localparam logic [1:0] CFG_STRUCTURE = 2'd2;

	localparam logic [1:0] TYPE_ASCII = 2'd0;
	localparam logic [1:0] TYPE_IMAGE = 2'd1;
	localparam logic [1:0] TYPE_LOCAL = 2'd2;

	localparam logic [1:0] MODE_STREAM = 2'd0;

	localparam logic [1:0] STRU_FILE   = 2'd0;
	localparam logic [1:0] STRU_RECORD = 2'd1;

	localparam logic [7:0] BYTE_ESC = 8'hFF;
	localparam logic [7:0] BYTE_EOR = 8'h01;
	localparam logic [7:0] BYTE_EOF = 8'h02;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_NUL = 8'h00;

	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] status;
		logic       last;
	} result_t;

endpackage

/* src/ftp_stream_receive_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftp_stream_receive_decoder
// Stream-mode FTP receive decoder: ASCII CR/LF and record escape handling.
// ----------------------------------------------------------------------------
// One input transfer can be taken every cycle while s_axis_tready is high.
// Each input is registered, then decoded into zero to two results held in a
// three-entry output buffer that hands out one result per cycle while
// m_axis_tready is high. Inputs with at most one result are taken at one input
// per cycle while the output is not stalled. A new input is decoded when it
// yields no result, or when the buffer is empty or is giving up its final
// entry. Config writes are taken every cycle; type and structure are sampled
// at a start item.
module ftp_stream_receive_decoder
	import fsrd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [2:0] s_axis_tuser,   // [2:0] op
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [2:0] m_axis_tuser,   // [2:0] status
	output logic       m_axis_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [1:0] cfg_data
);

	logic [1:0] data_type_q, mode_q, stru_q;
	logic       cr_q, esc_q, fin_q, ascii_q, record_q;

	logic       valid_s1;
	logic [2:0] op_s1;
	logic [7:0] byte_s1;

	result_t    res_q [MAX_RES];
	logic [1:0] rem_q;

	result_t    res_c [MAX_RES];
	logic [1:0] n_c;
	logic       cr_c, esc_c, fin_c, ascii_c, record_c;
	logic       ok_c;

	logic       free, advance, pop, s_acc;

	assign cfg_ready     = 1'b1;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign free          = (rem_q == 2'd0) || ((rem_q == 2'd1) && m_axis_tready);
	assign advance       = valid_s1 && ((n_c == 2'd0) || free);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = rem_q != 2'd0;
	assign m_axis_tdata  = res_q[0].data;
	assign m_axis_tuser  = res_q[0].status;
	assign m_axis_tlast  = res_q[0].last;

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			res_c[i] = '0;
		end
		n_c      = 2'd0;
		cr_c     = cr_q;
		esc_c    = esc_q;
		fin_c    = fin_q;
		ascii_c  = ascii_q;
		record_c = record_q;
		ok_c     = 1'b0;
		case (op_s1)
			OP_START: begin
				cr_c  = 1'b0;
				esc_c = 1'b0;
				case (data_type_q)
					TYPE_ASCII: ok_c = (mode_q == MODE_STREAM) &&
						((stru_q == STRU_FILE) || (stru_q == STRU_RECORD));
					TYPE_IMAGE, TYPE_LOCAL: ok_c = (mode_q == MODE_STREAM) &&
						(stru_q == STRU_FILE);
					default: ok_c = 1'b0;
				endcase
				if (!ok_c) begin
					fin_c = 1'b1;
					res_c[n_c] = '{BYTE_NUL, STAT_UNSUP, 1'b0};
					n_c = n_c + 2'd1;
				end else begin
					fin_c    = 1'b0;
					ascii_c  = data_type_q == TYPE_ASCII;
					record_c = (data_type_q == TYPE_ASCII) && (stru_q == STRU_RECORD);
				end
			end
			OP_DATA: begin
				if (!fin_q) begin
					if (!ascii_q) begin
						res_c[n_c] = '{byte_s1, STAT_BYTE, 1'b0};
						n_c = n_c + 2'd1;
					end else begin
						case (byte_s1)
							BYTE_CR: begin
								if (esc_c) begin
									esc_c = 1'b0;
									res_c[n_c] = '{BYTE_ESC, STAT_BYTE, 1'b0};
									n_c = n_c + 2'd1;
								end
								if (cr_c) begin
									res_c[n_c] = '{BYTE_CR, STAT_BYTE, 1'b0};
									n_c = n_c + 2'd1;
								end
								cr_c = 1'b1;
							end
							BYTE_LF: begin
								if (esc_c) begin
									esc_c = 1'b0;
									res_c[n_c] = '{BYTE_ESC, STAT_BYTE, 1'b0};
									n_c = n_c + 2'd1;
								end
								cr_c = 1'b0;
								res_c[n_c] = '{BYTE_LF, STAT_BYTE, 1'b0};
								n_c = n_c + 2'd1;
							end
							BYTE_NUL: begin
								if (esc_c) begin
									esc_c = 1'b0;
									res_c[n_c] = '{BYTE_ESC, STAT_BYTE, 1'b0};
									n_c = n_c + 2'd1;
								end
								if (cr_c) begin
									cr_c = 1'b0;
									res_c[n_c] = '{BYTE_CR, STAT_BYTE, 1'b0};
								end else begin
									res_c[n_c] = '{BYTE_NUL, STAT_BYTE, 1'b0};
								end
								n_c = n_c + 2'd1;
							end
							BYTE_ESC: begin
								if (cr_c) begin
									cr_c = 1'b0;
									res_c[n_c] = '{BYTE_CR, STAT_BYTE, 1'b0};
									n_c = n_c + 2'd1;
								end
								if (!record_q || esc_c) begin
									esc_c = 1'b0;
									res_c[n_c] = '{BYTE_ESC, STAT_BYTE, 1'b0};
									n_c = n_c + 2'd1;
								end else begin
									esc_c = 1'b1;
								end
							end
							BYTE_EOR, BYTE_EOF: begin
								if (esc_c) begin
									esc_c = 1'b0;
									if (byte_s1 == BYTE_EOR) begin
										res_c[n_c] = '{BYTE_LF, STAT_BYTE, 1'b0};
									end else begin
										cr_c  = 1'b0;
										fin_c = 1'b1;
										res_c[n_c] = '{BYTE_NUL, STAT_DONE, 1'b0};
									end
									n_c = n_c + 2'd1;
								end else begin
									if (cr_c) begin
										cr_c = 1'b0;
										res_c[n_c] = '{BYTE_CR, STAT_BYTE, 1'b0};
										n_c = n_c + 2'd1;
									end
									res_c[n_c] = '{byte_s1, STAT_BYTE, 1'b0};
									n_c = n_c + 2'd1;
								end
							end
							default: begin
								if (cr_c) begin
									cr_c = 1'b0;
									res_c[n_c] = '{BYTE_CR, STAT_BYTE, 1'b0};
									n_c = n_c + 2'd1;
								end
								if (esc_c) begin
									esc_c = 1'b0;
									res_c[n_c] = '{BYTE_ESC, STAT_BYTE, 1'b0};
									n_c = n_c + 2'd1;
								end
								res_c[n_c] = '{byte_s1, STAT_BYTE, 1'b0};
								n_c = n_c + 2'd1;
							end
						endcase
					end
				end
			end
			OP_CLOSE, OP_FAIL, OP_ABORT: begin
				if (!fin_q) begin
					cr_c  = 1'b0;
					esc_c = 1'b0;
					fin_c = 1'b1;
					case (op_s1)
						OP_CLOSE: res_c[n_c] = '{BYTE_NUL, STAT_DONE, 1'b0};
						OP_FAIL:  res_c[n_c] = '{BYTE_NUL, STAT_FAIL, 1'b0};
						default:  res_c[n_c] = '{BYTE_NUL, STAT_ABORT, 1'b0};
					endcase
					n_c = n_c + 2'd1;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < MAX_RES; i++) begin
			res_c[i].last = (n_c != 2'd0) && (2'(i) == n_c - 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_type_q <= TYPE_ASCII;
			mode_q      <= MODE_STREAM;
			stru_q      <= STRU_FILE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DATA_TYPE: data_type_q <= cfg_data;
				CFG_MODE:      mode_q      <= cfg_data;
				CFG_STRUCTURE: stru_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q     <= 1'b0;
			esc_q    <= 1'b0;
			fin_q    <= 1'b1;
			ascii_q  <= 1'b0;
			record_q <= 1'b0;
			valid_s1 <= 1'b0;
			rem_q    <= 2'd0;
		end else begin
			if (s_acc) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				cr_q     <= cr_c;
				esc_q    <= esc_c;
				fin_q    <= fin_c;
				ascii_q  <= ascii_c;
				record_q <= record_c;
			end
			if (advance && (n_c != 2'd0)) begin
				rem_q <= n_c;
			end else if (pop) begin
				rem_q <= rem_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1   <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
		if (advance && (n_c != 2'd0)) begin
			res_q <= res_c;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

endmodule

/* src/fsrd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsrd_checker
// Port-level checks for the FTP stream receive decoder, bound to the top level.
// ----------------------------------------------------------------------------
module fsrd_checker
	import fsrd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [2:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output transfer changed while stalled");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STAT_BYTE) |-> m_axis_tlast)
		else $error("status result not marked last");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STAT_BYTE) |-> m_axis_tdata == 8'h00)
		else $error("status result carries a byte");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser == STAT_BYTE) || (m_axis_tuser == STAT_DONE)
			|| (m_axis_tuser == STAT_ABORT) || (m_axis_tuser == STAT_FAIL)
			|| (m_axis_tuser == STAT_UNSUP))
		else $error("status code out of range");

	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind ftp_stream_receive_decoder fsrd_checker u_fsrd_checker (.*);
